// ----- rtl/cfca_pkg.sv -----
package cfca_pkg;

    // Frame layout of the sensor reply
    localparam int FRAME_BYTES    = 9;
    localparam int POS_W          = 4;
    localparam int POS_PPM_HIGH   = 2;
    localparam int POS_PPM_LOW    = 3;
    localparam int POS_LAST_SUM   = FRAME_BYTES - 2;
    localparam int POS_CHECK      = FRAME_BYTES - 1;

    localparam int BYTE_W         = 8;
    localparam int PPM_W          = 16;
    localparam int VALUE_W        = 18;
    localparam int OFFSET_W       = 17;

    localparam int WINDOW_SAMPLES_DEFAULT = 8;
    localparam logic [PPM_W-1:0] CAL_BASE_RESET = 16'd400;

    localparam int QUEUE_DEPTH    = 2;

    // Frame status codes
    localparam logic STATUS_GOOD  = 1'b0;
    localparam logic STATUS_BAD   = 1'b1;

    // One finished frame, handed from the front end to the back end
    typedef struct packed {
        logic             bad;
        logic [PPM_W-1:0] ppm;
        logic             cal;
    } frame_item_t;

endpackage

// ----- rtl/cfca_channels.sv -----
interface cfca_frame_if;
    import cfca_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_start;
    logic              calibrate;

    modport source (output valid, rx_byte, frame_start, calibrate, input ready);
    modport sink (input valid, rx_byte, frame_start, calibrate, output ready);
endinterface

interface cfca_result_if;
    import cfca_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       frame_status;
    logic signed [VALUE_W-1:0]  co2_value;
    logic signed [OFFSET_W-1:0] offset_now;
    logic                       calibrated;

    modport source (output valid, frame_status, co2_value, offset_now, calibrated,
                    input ready);
    modport sink (input valid, frame_status, co2_value, offset_now, calibrated,
                  output ready);
endinterface

interface cfca_cfg_if;
    import cfca_pkg::*;
    logic             valid;
    logic             ready;
    logic [PPM_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- rtl/cfca_front.sv -----
module cfca_front (
    input  logic                 clk,
    input  logic                 rst_n,
    cfca_frame_if.sink           frame,
    input  logic                 q_full,
    output logic                 push,
    output cfca_pkg::frame_item_t push_item
);
    import cfca_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] ppm_hi_reg, ppm_hi_next;
    logic [BYTE_W-1:0] ppm_lo_reg, ppm_lo_next;
    logic [POS_W-1:0]  pos;
    logic              accept;

    assign frame.ready = !q_full;
    assign accept      = frame.valid && frame.ready;
    assign pos         = frame.frame_start ? '0 : pos_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        ppm_hi_next = ppm_hi_reg;
        ppm_lo_next = ppm_lo_reg;
        push        = 1'b0;
        push_item.bad = (BYTE_W'(0) - sum_reg) != frame.rx_byte;
        push_item.ppm = {ppm_hi_reg, ppm_lo_reg};
        push_item.cal = frame.calibrate;
        if (accept && (pos < POS_W'(FRAME_BYTES)))
        begin
            if (pos == '0)
                sum_next = '0;
            else if (pos <= POS_W'(POS_LAST_SUM))
                sum_next = sum_reg + frame.rx_byte;
            if (pos == POS_W'(POS_PPM_HIGH))
                ppm_hi_next = frame.rx_byte;
            if (pos == POS_W'(POS_PPM_LOW))
                ppm_lo_next = frame.rx_byte;
            if (pos == POS_W'(POS_CHECK))
            begin
                push     = 1'b1;
                pos_next = POS_W'(FRAME_BYTES);
            end
            else
                pos_next = pos + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            ppm_hi_reg <= '0;
            ppm_lo_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            ppm_hi_reg <= ppm_hi_next;
            ppm_lo_reg <= ppm_lo_next;
        end
    end

endmodule

// ----- rtl/cfca_queue.sv -----
module cfca_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cfca_pkg::frame_item_t push_item,
    input  logic                  pop,
    output logic                  full,
    output logic                  q_valid,
    output cfca_pkg::frame_item_t q_item
);
    import cfca_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_item_t      slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

`ifndef ASSERT_OFF
    // front end must hold off when there is no room
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ----- rtl/cfca_back.sv -----
module cfca_back #(
    parameter int WINDOW_SAMPLES = cfca_pkg::WINDOW_SAMPLES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    cfca_cfg_if.sink              cfg,
    input  logic                  q_valid,
    input  cfca_pkg::frame_item_t q_item,
    output logic                  pop,
    cfca_result_if.source         result
);
    import cfca_pkg::*;

    localparam int LOG_N  = $clog2(WINDOW_SAMPLES);
    localparam int SUM_W  = PPM_W + LOG_N;
    localparam int SHIFT  = SUM_W + LOG_N;
    localparam int PROD_W = 2 * SUM_W + 1;
    // ceil(2^SHIFT / N): exact floor division for every sum below 2^SUM_W
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(WINDOW_SAMPLES) - 64'd1) / 64'(WINDOW_SAMPLES);
    localparam logic [SUM_W:0] RECIP = RECIP_WIDE[SUM_W:0];

    logic [PPM_W-1:0]           base_reg;
    logic [PPM_W-1:0]           win_reg [WINDOW_SAMPLES];
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic signed [OFFSET_W-1:0] offset_reg, offset_next;

    logic                       s1_valid_reg, s1_bad_reg, s1_cal_reg;
    logic                       s2_valid_reg, s2_bad_reg, s2_cal_reg;
    logic [PROD_W-1:0]          prod_reg;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_status_reg;
    logic signed [VALUE_W-1:0]  out_value_reg;
    logic signed [OFFSET_W-1:0] out_offset_reg;
    logic                       out_cal_reg;

    logic [PPM_W-1:0]           mean;
    logic signed [VALUE_W-1:0]  value;
    logic signed [OFFSET_W-1:0] cal_offset;
    logic [SUM_W:0]             sum_wide;

    assign cfg.ready = 1'b1;

    // one frame in flight at a time
    assign pop = q_valid && !s1_valid_reg && !s2_valid_reg && !out_valid_reg;

    assign sum_wide = {1'b0, sum_reg} - (SUM_W + 1)'(win_reg[0]) + (SUM_W + 1)'(q_item.ppm);
    assign sum_next = (pop && !q_item.bad) ? sum_wide[SUM_W-1:0] : sum_reg;

    assign mean       = prod_reg[SHIFT +: PPM_W];
    assign value      = signed'({2'b00, mean}) + signed'({offset_reg[OFFSET_W-1], offset_reg});
    assign cal_offset = signed'({1'b0, base_reg}) - signed'({1'b0, mean});

    always_comb
    begin
        offset_next    = offset_reg;
        out_valid_next = out_valid_reg;
        if (result.valid && result.ready)
            out_valid_next = 1'b0;
        if (s2_valid_reg)
        begin
            out_valid_next = 1'b1;
            if (!s2_bad_reg && s2_cal_reg)
                offset_next = cal_offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= CAL_BASE_RESET;
            sum_reg       <= '0;
            offset_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_SAMPLES; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                base_reg <= cfg.data;
            sum_reg       <= sum_next;
            offset_reg    <= offset_next;
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
            if (pop && !q_item.bad)
            begin
                for (int i = 0; i < WINDOW_SAMPLES - 1; i++)
                    win_reg[i] <= win_reg[i + 1];
                win_reg[WINDOW_SAMPLES - 1] <= q_item.ppm;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_bad_reg <= q_item.bad;
            s1_cal_reg <= q_item.cal;
        end
        s2_bad_reg <= s1_bad_reg;
        s2_cal_reg <= s1_cal_reg;
        prod_reg   <= PROD_W'(sum_reg) * PROD_W'(RECIP);
        if (s2_valid_reg)
        begin
            if (s2_bad_reg)
            begin
                out_status_reg <= STATUS_BAD;
                out_value_reg  <= '0;
                out_offset_reg <= offset_reg;
                out_cal_reg    <= 1'b0;
            end
            else
            begin
                out_status_reg <= STATUS_GOOD;
                out_value_reg  <= value;
                out_offset_reg <= s2_cal_reg ? cal_offset : offset_reg;
                out_cal_reg    <= s2_cal_reg;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.frame_status = out_status_reg;
    assign result.co2_value    = out_value_reg;
    assign result.offset_now   = out_offset_reg;
    assign result.calibrated   = out_cal_reg;

`ifndef ASSERT_OFF
    a_single_frame: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({s1_valid_reg, s2_valid_reg, out_valid_reg}))
        else $error("more than one frame in the back end");
    a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> s2_valid_reg && !s1_valid_reg)
        else $error("multiply stage lost a frame");
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |=> out_valid_reg)
        else $error("result not registered after multiply");
`endif

endmodule

// ----- rtl/co2_frame_check_average_calibrate.sv -----
// Sensor reply checker: takes the nine-byte reply one byte per item, counts
// positions from frame_start, checks the two's-complement checksum of bytes 1
// to 7 against byte 8 and, on a good frame, pushes the big-endian ppm word of
// bytes 2 and 3 into a zero-cleared moving window of WINDOW_SAMPLES samples.
// Each frame gives one result item on its last byte: the truncated mean plus
// the calibration offset, the offset after the frame and a calibrated flag.
// A calibrate request on a good frame's last byte sets offset = base - mean;
// on a bad frame it is dropped and window, sum and offset are left alone.
// Rate: one byte is taken every cycle while the queue has room. A frame's
// result follows its last byte through window update, reciprocal multiply
// and offset add; the back end holds one frame at a time, and a two-item
// queue between front and back absorbs a stalled result. No clearing pass
// after reset: the window is in flip-flops cleared by reset. calibration_base
// is written through the cfg channel, which is always ready.
module co2_frame_check_average_calibrate #(
    parameter int WINDOW_SAMPLES = cfca_pkg::WINDOW_SAMPLES_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    cfca_frame_if.sink    frame,
    cfca_result_if.source result,
    cfca_cfg_if.sink      cfg
);
    import cfca_pkg::*;

    logic        push;
    frame_item_t push_item;
    logic        q_full;
    logic        q_valid;
    frame_item_t q_item;
    logic        pop;

    // byte framing and checksum
    cfca_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // finished frames waiting for the back end
    cfca_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // moving average, offset and result register
    cfca_back #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .result  (result)
    );

endmodule
